/* hdl/mlcq_pkg.sv */
// ----------------------------------------------------------------------------
// mlcq_pkg
// Shared types and constants for the multi-lane chunk queue.
// ----------------------------------------------------------------------------
package mlcq_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 24;
    localparam int TOT_W  = 30;
    localparam int CMD_W  = 3;
    localparam int LANE_W = 3;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 7;

    localparam logic [TOT_W-1:0] TOTAL_MAX     = '1;
    localparam logic [CFG_W-1:0] POOL_USED_RST = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET   = 3'd0,
        CMD_PUT   = 3'd1,
        CMD_UNGET = 3'd2,
        CMD_PEEK  = 3'd3,
        CMD_COUNT = 3'd4,
        CMD_CLEAR = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_LANE   = 2'd1,
        ST_POOL_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        REG_JOIN_MODE = 1'b0,
        REG_POOL_USED = 1'b1
    } reg_idx_t;

    // Phase commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic rd1;
        logic ev1;
        logic rdf;
        logic evf;
        logic wrt;
        logic finish;
    } ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic alloc;
        logic link_tail;
        logic out_free;
    } stat_t;

endpackage

/* hdl/mlcq_ram.sv */
// ----------------------------------------------------------------------------
// mlcq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mlcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/mlcq_ctrl.sv */
// ----------------------------------------------------------------------------
// mlcq_ctrl
// Command sequencer: steps each item through read, evaluate, allocate and
// link phases, and hands the result to the output register.
// ----------------------------------------------------------------------------
module mlcq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mlcq_pkg::stat_t st,
    output mlcq_pkg::ctl_t  ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_EV1,
        S_RDF,
        S_EVF,
        S_WRT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_RD1;
            S_RD1:  state_next = S_EV1;
            S_EV1:  state_next = st.alloc ? S_RDF : S_DONE;
            S_RDF:  state_next = S_EVF;
            S_EVF:  state_next = st.link_tail ? S_WRT : S_DONE;
            S_WRT:  state_next = S_DONE;
            S_DONE: if (st.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready   = in_ready_reg;
    assign ctl.load   = in_valid && in_ready_reg;
    assign ctl.rd1    = (state_reg == S_RD1);
    assign ctl.ev1    = (state_reg == S_EV1);
    assign ctl.rdf    = (state_reg == S_RDF);
    assign ctl.evf    = (state_reg == S_EVF);
    assign ctl.wrt    = (state_reg == S_WRT);
    assign ctl.finish = (state_reg == S_DONE) && st.out_free;

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(ctl))
        else $error("more than one phase active");

    a_load_then_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> ctl.rd1)
        else $error("accepted item not followed by read phase");

    a_alloc_seq: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rdf |=> ctl.evf)
        else $error("free read not followed by allocation");

endmodule

/* hdl/mlcq_dp.sv */
// ----------------------------------------------------------------------------
// mlcq_dp
// Datapath: descriptor RAM, lane head/tail/byte registers, free list with
// untouched-entry pointer, configuration and result registers.
// ----------------------------------------------------------------------------
module mlcq_dp #(
    parameter int POOL_DEPTH = 64,
    parameter int LANE_COUNT = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mlcq_pkg::CMD_W-1:0]    command,
    input  logic [mlcq_pkg::LANE_W-1:0]   lane,
    input  logic [mlcq_pkg::ADDR_W-1:0]   chunk_addr,
    input  logic [mlcq_pkg::LEN_W-1:0]    chunk_len,
    input  logic [mlcq_pkg::LEN_W-1:0]    request_len,
    input  logic                          cfg_valid,
    input  logic [0:0]                    cfg_index,
    input  logic [mlcq_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [mlcq_pkg::ADDR_W-1:0]   out_addr,
    output logic [mlcq_pkg::LEN_W-1:0]    out_len,
    output logic                          ready_res,
    output logic [mlcq_pkg::TOT_W-1:0]    byte_total,
    output logic [mlcq_pkg::STAT_W-1:0]   status,
    input  mlcq_pkg::ctl_t                ctl,
    output mlcq_pkg::stat_t               st
);

    localparam int AW  = $clog2(POOL_DEPTH);
    localparam int PW  = $clog2(POOL_DEPTH + 1);
    localparam int LIW = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
    localparam int BTW = ($clog2(POOL_DEPTH) + 25 > 31) ? $clog2(POOL_DEPTH) + 25 : 31;
    localparam int AL  = mlcq_pkg::ADDR_W;
    localparam int LL  = mlcq_pkg::LEN_W;
    localparam int DW  = AL + LL + PW;
    localparam logic [PW-1:0] NIL      = PW'(POOL_DEPTH);
    localparam logic [PW-1:0] NLIM_RST = PW'((64 > POOL_DEPTH) ? POOL_DEPTH : 64);

    // item registers
    logic [mlcq_pkg::CMD_W-1:0]  cmd_reg;
    logic [mlcq_pkg::LANE_W-1:0] lane_reg;
    logic [AL-1:0]               addr_reg;
    logic [LL-1:0]               clen_reg;
    logic [LL-1:0]               req_reg;

    // lane and pool state
    logic [PW-1:0]  head_reg  [LANE_COUNT];
    logic [PW-1:0]  head_next [LANE_COUNT];
    logic [PW-1:0]  tail_reg  [LANE_COUNT];
    logic [PW-1:0]  tail_next [LANE_COUNT];
    logic [BTW-1:0] bytes_reg  [LANE_COUNT];
    logic [BTW-1:0] bytes_next [LANE_COUNT];
    logic [PW-1:0]  free_reg, free_next;
    logic [PW-1:0]  fresh_reg, fresh_next;
    logic [PW-1:0]  nlim_reg, nlim_next;
    logic           join_reg;
    logic [mlcq_pkg::CFG_W-1:0] pool_used_reg;

    // working registers
    logic [DW-1:0] w1_reg;
    logic [PW-1:0] ptr1_reg, ptr1_next;
    logic [PW-1:0] new_reg, new_next;

    // result and output registers
    logic [AL-1:0] res_addr_reg, res_addr_next;
    logic [LL-1:0] res_len_reg, res_len_next;
    logic          res_rdy_reg, res_rdy_next;
    logic [mlcq_pkg::TOT_W-1:0]  res_tot_reg, res_tot_next;
    logic [mlcq_pkg::STAT_W-1:0] res_stat_reg, res_stat_next;
    logic          out_valid_reg;
    logic [AL-1:0] o_addr_reg;
    logic [LL-1:0] o_len_reg;
    logic          o_rdy_reg;
    logic [mlcq_pkg::TOT_W-1:0]  o_tot_reg;
    logic [mlcq_pkg::STAT_W-1:0] o_stat_reg;

    // RAM port
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;

    // decoded item
    mlcq_pkg::cmd_t cmd;
    logic [LIW-1:0] li;
    logic           bad, null_chunk, head_live, tail_live, free_live, free_fresh;
    logic [PW-1:0]  h, t, fresh_link, rptr;
    logic [AL-1:0]  r_addr;
    logic [LL-1:0]  r_len;
    logic [PW-1:0]  r_next;
    logic [AL:0]    sum_put, sum_ung;
    logic [LL:0]    len_sum;
    logic           merge, is_alloc_cmd;
    logic [BTW-1:0] bsel;
    logic [31:0]    pu32, eff32;

    mlcq_ram #(
        .WIDTH (DW),
        .DEPTH (POOL_DEPTH)
    ) u_desc_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cmd        = mlcq_pkg::cmd_t'(cmd_reg);
    assign li         = LIW'(lane_reg);
    assign bad        = 32'(lane_reg) >= 32'(LANE_COUNT);
    assign h          = head_reg[li];
    assign t          = tail_reg[li];
    assign bsel       = bytes_reg[li];
    assign head_live  = h < NIL;
    assign tail_live  = t < NIL;
    assign free_live  = free_reg < NIL;
    assign free_fresh = free_reg >= fresh_reg;
    assign null_chunk = (addr_reg == '0) || (clen_reg == '0);
    assign fresh_link = (32'(free_reg) + 32'd1 < 32'(nlim_reg))
                        ? PW'(32'(free_reg) + 32'd1) : NIL;

    assign r_addr = rdata[DW-1 -: AL];
    assign r_len  = rdata[PW +: LL];
    assign r_next = rdata[PW-1:0];

    // contiguity without address wrap, merged length must fit
    assign sum_put = {1'b0, r_addr} + (AL+1)'(r_len);
    assign sum_ung = {1'b0, addr_reg} + (AL+1)'(clen_reg);
    assign len_sum = {1'b0, r_len} + {1'b0, clen_reg};
    assign is_alloc_cmd = (cmd == mlcq_pkg::CMD_PUT) || (cmd == mlcq_pkg::CMD_UNGET);
    assign merge = join_reg && !len_sum[LL] &&
                   ((cmd == mlcq_pkg::CMD_PUT)
                    ? (tail_live && sum_put == {1'b0, addr_reg})
                    : (head_live && sum_ung == {1'b0, r_addr}));

    assign pu32  = 32'(pool_used_reg);
    assign eff32 = (pu32 == 32'd0) ? 32'd1
                 : ((pu32 > 32'(POOL_DEPTH)) ? 32'(POOL_DEPTH) : pu32);

    assign st.alloc     = ctl.ev1 && is_alloc_cmd && !bad && !null_chunk
                          && !merge && free_live;
    assign st.link_tail = (cmd == mlcq_pkg::CMD_PUT) && tail_live;
    assign st.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        bytes_next    = bytes_reg;
        free_next     = free_reg;
        fresh_next    = fresh_reg;
        nlim_next     = nlim_reg;
        ptr1_next     = ptr1_reg;
        new_next      = new_reg;
        res_addr_next = res_addr_reg;
        res_len_next  = res_len_reg;
        res_rdy_next  = res_rdy_reg;
        res_tot_next  = res_tot_reg;
        res_stat_next = res_stat_reg;
        we            = 1'b0;
        waddr         = h[AW-1:0];
        wdata         = rdata;
        re            = 1'b0;
        rptr          = (cmd == mlcq_pkg::CMD_PUT) ? t : h;
        raddr         = rptr[AW-1:0];

        if (ctl.rd1)
        begin
            re = !bad && (rptr < NIL);
        end

        if (ctl.rdf)
        begin
            re    = !free_fresh;
            raddr = free_reg[AW-1:0];
        end

        if (ctl.ev1)
        begin
            ptr1_next     = t;
            res_addr_next = '0;
            res_len_next  = '0;
            res_rdy_next  = 1'b0;
            res_tot_next  = '0;
            res_stat_next = mlcq_pkg::ST_OK;
            if (cmd == mlcq_pkg::CMD_CLEAR)
            begin
                free_next  = '0;
                fresh_next = '0;
                nlim_next  = PW'(eff32);
                for (int i = 0; i < LANE_COUNT; i++)
                begin
                    head_next[i]  = NIL;
                    tail_next[i]  = NIL;
                    bytes_next[i] = '0;
                end
            end
            else if (bad && cmd_reg <= mlcq_pkg::CMD_COUNT)
            begin
                res_stat_next = mlcq_pkg::ST_BAD_LANE;
            end
            else
            begin
                case (cmd)
                    mlcq_pkg::CMD_GET:
                    begin
                        if (head_live)
                        begin
                            if (req_reg >= r_len)
                            begin
                                // pop the head onto the free list
                                res_addr_next = r_addr;
                                res_len_next  = r_len;
                                we            = 1'b1;
                                wdata         = {r_addr, r_len, free_reg};
                                head_next[li] = r_next;
                                if (r_next >= NIL)
                                begin
                                    tail_next[li] = NIL;
                                end
                                free_next      = h;
                                bytes_next[li] = bsel - BTW'(r_len);
                            end
                            else if (join_reg)
                            begin
                                // split the head
                                res_addr_next  = r_addr;
                                res_len_next   = req_reg;
                                we             = 1'b1;
                                wdata          = {r_addr + AL'(req_reg), r_len - req_reg,
                                                  r_next};
                                bytes_next[li] = bsel - BTW'(req_reg);
                            end
                        end
                    end
                    mlcq_pkg::CMD_PUT, mlcq_pkg::CMD_UNGET:
                    begin
                        if (!null_chunk)
                        begin
                            if (merge)
                            begin
                                we             = 1'b1;
                                bytes_next[li] = bsel + BTW'(clen_reg);
                                if (cmd == mlcq_pkg::CMD_PUT)
                                begin
                                    waddr = t[AW-1:0];
                                    wdata = {r_addr, len_sum[LL-1:0], r_next};
                                end
                                else
                                begin
                                    wdata = {addr_reg, len_sum[LL-1:0], r_next};
                                end
                            end
                            else if (!free_live)
                            begin
                                res_stat_next = mlcq_pkg::ST_POOL_EMPTY;
                            end
                        end
                    end
                    mlcq_pkg::CMD_PEEK:
                    begin
                        if (head_live)
                        begin
                            res_len_next = r_len;
                            res_rdy_next = join_reg ? (r_len >= req_reg)
                                                    : (r_len == req_reg);
                        end
                    end
                    mlcq_pkg::CMD_COUNT:
                    begin
                        res_tot_next = (bsel > BTW'(mlcq_pkg::TOTAL_MAX))
                                       ? mlcq_pkg::TOTAL_MAX : bsel[mlcq_pkg::TOT_W-1:0];
                    end
                    default: ;
                endcase
            end
        end

        if (ctl.evf)
        begin
            // take the free head; an untouched entry links to its successor
            new_next  = free_reg;
            free_next = free_fresh ? fresh_link : r_next;
            if (free_fresh)
            begin
                fresh_next = free_reg + PW'(1);
            end
            we             = 1'b1;
            waddr          = free_reg[AW-1:0];
            bytes_next[li] = bsel + BTW'(clen_reg);
            if (cmd == mlcq_pkg::CMD_PUT)
            begin
                wdata = {addr_reg, clen_reg, NIL};
                if (!tail_live)
                begin
                    head_next[li] = free_reg;
                end
                tail_next[li] = free_reg;
            end
            else
            begin
                wdata         = {addr_reg, clen_reg, h};
                head_next[li] = free_reg;
                if (!tail_live)
                begin
                    tail_next[li] = free_reg;
                end
            end
        end

        if (ctl.wrt)
        begin
            // link the old tail to the new entry
            we    = 1'b1;
            waddr = ptr1_reg[AW-1:0];
            wdata = {w1_reg[DW-1:PW], new_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_COUNT; i++)
            begin
                head_reg[i]  <= NIL;
                tail_reg[i]  <= NIL;
                bytes_reg[i] <= '0;
            end
            free_reg      <= '0;
            fresh_reg     <= '0;
            nlim_reg      <= NLIM_RST;
            join_reg      <= 1'b0;
            pool_used_reg <= mlcq_pkg::POOL_USED_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            bytes_reg <= bytes_next;
            free_reg  <= free_next;
            fresh_reg <= fresh_next;
            nlim_reg  <= nlim_next;
            if (cfg_valid)
            begin
                unique case (mlcq_pkg::reg_idx_t'(cfg_index))
                    mlcq_pkg::REG_JOIN_MODE: join_reg      <= cfg_data[0];
                    mlcq_pkg::REG_POOL_USED: pool_used_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (ctl.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= command;
            lane_reg <= lane;
            addr_reg <= chunk_addr;
            clen_reg <= chunk_len;
            req_reg  <= request_len;
        end
        if (ctl.ev1)
        begin
            w1_reg <= rdata;
        end
        ptr1_reg     <= ptr1_next;
        new_reg      <= new_next;
        res_addr_reg <= res_addr_next;
        res_len_reg  <= res_len_next;
        res_rdy_reg  <= res_rdy_next;
        res_tot_reg  <= res_tot_next;
        res_stat_reg <= res_stat_next;
        if (ctl.finish)
        begin
            o_addr_reg <= res_addr_reg;
            o_len_reg  <= res_len_reg;
            o_rdy_reg  <= res_rdy_reg;
            o_tot_reg  <= res_tot_reg;
            o_stat_reg <= res_stat_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_addr   = o_addr_reg;
    assign out_len    = o_len_reg;
    assign ready_res  = o_rdy_reg;
    assign byte_total = o_tot_reg;
    assign status     = o_stat_reg;

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= nlim_reg)
        else $error("untouched-entry pointer beyond pool size");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg != NIL) |-> (free_reg < nlim_reg))
        else $error("free head outside the pool");

    a_alloc_live: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.evf |-> (free_reg != NIL))
        else $error("allocation from an empty free list");

endmodule

/* hdl/multi_lane_chunk_queue.sv */
// ----------------------------------------------------------------------------
// multi_lane_chunk_queue
// Linked-list chunk descriptor queues over a shared free pool.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | in        | in_valid / in_ready  | command lane chunk_addr
//           |           |                      | chunk_len request_len
//   out     | out       | out_valid/out_ready  | out_addr out_len ready_res
//           |           |                      | byte_total status
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index cfg_data
//
// One item at a time. Get, peek, count, clear, merges and error cases pass
// through the read and evaluate steps; put or unget into a new descriptor
// adds a free-list read and an allocation, and a link write when a tail is
// linked. The step sequence is set by the descriptor RAM, with one write
// port, one read port and a registered read. Untouched pool entries are
// tracked by a pointer, so reset runs no clearing pass. A result waiting on
// out_ready stalls the item behind it only at its final step.
// ----------------------------------------------------------------------------
module multi_lane_chunk_queue #(
    parameter int POOL_DEPTH = 64,
    parameter int LANE_COUNT = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mlcq_pkg::CMD_W-1:0]    command,
    input  logic [mlcq_pkg::LANE_W-1:0]   lane,
    input  logic [mlcq_pkg::ADDR_W-1:0]   chunk_addr,
    input  logic [mlcq_pkg::LEN_W-1:0]    chunk_len,
    input  logic [mlcq_pkg::LEN_W-1:0]    request_len,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mlcq_pkg::ADDR_W-1:0]   out_addr,
    output logic [mlcq_pkg::LEN_W-1:0]    out_len,
    output logic                          ready_res,
    output logic [mlcq_pkg::TOT_W-1:0]    byte_total,
    output logic [mlcq_pkg::STAT_W-1:0]   status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_index,
    input  logic [mlcq_pkg::CFG_W-1:0]    cfg_data
);

    mlcq_pkg::ctl_t  ctl;
    mlcq_pkg::stat_t st;

    assign cfg_ready = 1'b1;

    mlcq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .ctl      (ctl)
    );

    mlcq_dp #(
        .POOL_DEPTH (POOL_DEPTH),
        .LANE_COUNT (LANE_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .lane        (lane),
        .chunk_addr  (chunk_addr),
        .chunk_len   (chunk_len),
        .request_len (request_len),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_addr    (out_addr),
        .out_len     (out_len),
        .ready_res   (ready_res),
        .byte_total  (byte_total),
        .status      (status),
        .ctl         (ctl),
        .st          (st)
    );

endmodule

/* tb/multi_lane_chunk_queue_test.sv */
// ----------------------------------------------------------------------------
// multi_lane_chunk_queue_test
// Self-checking bench for the multi-lane chunk queue: a behavioural copy of
// the lane lists and free pool predicts every result, which is compared field
// by field with the block's output under random idling on both channels.
// ----------------------------------------------------------------------------
module multi_lane_chunk_queue_test;

    localparam int DEPTH = 64;
    localparam int LANES = 4;
    localparam logic [6:0] NIL = 7'd64;
    localparam logic [mlcq_pkg::LEN_W-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic [mlcq_pkg::ADDR_W-1:0] addr;
        logic [mlcq_pkg::LEN_W-1:0]  len;
        logic                        rdy;
        logic [mlcq_pkg::TOT_W-1:0]  total;
        logic [mlcq_pkg::STAT_W-1:0] stat;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0, in_ready;
    logic [mlcq_pkg::CMD_W-1:0] command = '0;
    logic [mlcq_pkg::LANE_W-1:0] lane = '0;
    logic [mlcq_pkg::ADDR_W-1:0] chunk_addr = '0;
    logic [mlcq_pkg::LEN_W-1:0] chunk_len = '0, request_len = '0;
    logic out_valid, out_ready = 1'b0;
    logic [mlcq_pkg::ADDR_W-1:0] out_addr;
    logic [mlcq_pkg::LEN_W-1:0] out_len;
    logic ready_res;
    logic [mlcq_pkg::TOT_W-1:0] byte_total;
    logic [mlcq_pkg::STAT_W-1:0] status;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [0:0] cfg_index = '0;
    logic [mlcq_pkg::CFG_W-1:0] cfg_data = '0;

    // shadow of the queue state
    logic [mlcq_pkg::ADDR_W-1:0] sh_addr [DEPTH];
    logic [mlcq_pkg::LEN_W-1:0]  sh_len  [DEPTH];
    logic [6:0]                  sh_next [DEPTH];
    logic [6:0]                  sh_head [LANES];
    logic [6:0]                  sh_tail [LANES];
    longint                      sh_bytes [LANES];
    logic [6:0]                  sh_free;
    logic                        sh_join;
    logic [mlcq_pkg::CFG_W-1:0]  sh_pool;

    result_t expected_results [$];
    int mismatches = 0;
    int send_idle = 0;
    int recv_stall = 0;

    multi_lane_chunk_queue i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    function automatic void rebuild_pool();
        int n;
        n = (sh_pool == 0) ? 1 : ((sh_pool > DEPTH) ? DEPTH : int'(sh_pool));
        for (int i = 0; i < DEPTH; i++)
        begin
            sh_addr[i] = '0;
            sh_len[i] = '0;
            sh_next[i] = (i + 1 < n) ? 7'(i + 1) : NIL;
        end
        sh_free = '0;
        for (int i = 0; i < LANES; i++)
        begin
            sh_head[i] = NIL;
            sh_tail[i] = NIL;
            sh_bytes[i] = 0;
        end
    endfunction

    function automatic result_t predict_queue(logic [2:0] cmd, logic [2:0] ln,
            logic [mlcq_pkg::ADDR_W-1:0] ca, logic [mlcq_pkg::LEN_W-1:0] cl,
            logic [mlcq_pkg::LEN_W-1:0] rq);
        result_t r;
        logic [6:0] h, t, n;
        r = '0;
        if (cmd == mlcq_pkg::CMD_CLEAR)
            rebuild_pool();
        else if (cmd <= mlcq_pkg::CMD_COUNT && ln >= LANES)
            r.stat = mlcq_pkg::ST_BAD_LANE;
        else if (cmd == mlcq_pkg::CMD_GET)
        begin
            h = sh_head[ln];
            if (h != NIL)
            begin
                if (rq >= sh_len[h])
                begin
                    r.addr = sh_addr[h];
                    r.len = sh_len[h];
                    sh_head[ln] = sh_next[h];
                    if (sh_head[ln] == NIL)
                        sh_tail[ln] = NIL;
                    sh_next[h] = sh_free;
                    sh_free = h;
                    sh_bytes[ln] -= sh_len[h];
                end
                else if (sh_join)
                begin
                    r.addr = sh_addr[h];
                    r.len = rq;
                    sh_addr[h] = sh_addr[h] + rq;
                    sh_len[h] = sh_len[h] - rq;
                    sh_bytes[ln] -= rq;
                end
            end
        end
        else if (cmd == mlcq_pkg::CMD_PUT || cmd == mlcq_pkg::CMD_UNGET)
        begin
            if (cl != 0 && ca != 0)
            begin
                t = sh_tail[ln];
                h = sh_head[ln];
                if (cmd == mlcq_pkg::CMD_PUT && sh_join && t != NIL
                        && {1'b0, sh_addr[t]} + sh_len[t] == {1'b0, ca}
                        && {1'b0, sh_len[t]} + cl <= LEN_MAX)
                begin
                    sh_len[t] += cl;
                    sh_bytes[ln] += cl;
                end
                else if (cmd == mlcq_pkg::CMD_UNGET && sh_join && h != NIL
                        && {1'b0, ca} + cl == {1'b0, sh_addr[h]}
                        && {1'b0, sh_len[h]} + cl <= LEN_MAX)
                begin
                    sh_addr[h] = ca;
                    sh_len[h] += cl;
                    sh_bytes[ln] += cl;
                end
                else if (sh_free == NIL)
                    r.stat = mlcq_pkg::ST_POOL_EMPTY;
                else
                begin
                    n = sh_free;
                    sh_free = sh_next[n];
                    sh_addr[n] = ca;
                    sh_len[n] = cl;
                    sh_bytes[ln] += cl;
                    if (cmd == mlcq_pkg::CMD_PUT)
                    begin
                        sh_next[n] = NIL;
                        if (t != NIL)
                            sh_next[t] = n;
                        else
                            sh_head[ln] = n;
                        sh_tail[ln] = n;
                    end
                    else
                    begin
                        sh_next[n] = h;
                        sh_head[ln] = n;
                        if (sh_tail[ln] == NIL)
                            sh_tail[ln] = n;
                    end
                end
            end
        end
        else if (cmd == mlcq_pkg::CMD_PEEK)
        begin
            h = sh_head[ln];
            if (h != NIL)
            begin
                r.len = sh_len[h];
                r.rdy = sh_join ? (sh_len[h] >= rq) : (sh_len[h] == rq);
            end
        end
        else if (cmd == mlcq_pkg::CMD_COUNT)
            r.total = (sh_bytes[ln] > mlcq_pkg::TOTAL_MAX)
                      ? mlcq_pkg::TOTAL_MAX : mlcq_pkg::TOT_W'(sh_bytes[ln]);
        return r;
    endfunction

    task automatic send_item(logic [2:0] cmd, logic [2:0] ln,
            logic [mlcq_pkg::ADDR_W-1:0] ca, logic [mlcq_pkg::LEN_W-1:0] cl,
            logic [mlcq_pkg::LEN_W-1:0] rq);
        // drive the item on a falling edge after the previous one was dropped, with optional random idling
        @(negedge clk);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
            @(negedge clk);
        command <= cmd;
        lane <= ln;
        chunk_addr <= ca;
        chunk_len <= cl;
        request_len <= rq;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(predict_queue(cmd, ln, ca, cl, rq));
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(mlcq_pkg::reg_idx_t idx, logic [mlcq_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == mlcq_pkg::REG_JOIN_MODE)
            sh_join = val[0];
        else
            sh_pool = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
        out_ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);

    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{out_addr, out_len, ready_res, byte_total, status};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected addr %h len %h rdy %b tot %h st %h,",
                                  " got addr %h len %h rdy %b tot %h st %h"},
                            want.addr, want.len, want.rdy, want.total, want.stat,
                            got.addr, got.len, got.rdy, got.total, got.stat);
                end
            end
        end
    end

    task automatic test_directed();
        send_item(mlcq_pkg::CMD_GET, 0, 0, 0, 5);
        send_item(mlcq_pkg::CMD_PEEK, 1, 0, 0, 0);
        send_item(mlcq_pkg::CMD_PUT, 0, 0, 10, 0);
        send_item(mlcq_pkg::CMD_PUT, 0, 32'h100, 0, 0);
        send_item(mlcq_pkg::CMD_PUT, 0, 32'h100, 16, 0);
        send_item(mlcq_pkg::CMD_PUT, 0, 32'h110, 16, 0);
        send_item(mlcq_pkg::CMD_UNGET, 0, 32'hFFFF_FFFF, LEN_MAX, 0);
        send_item(mlcq_pkg::CMD_PEEK, 0, 0, 0, LEN_MAX);
        send_item(mlcq_pkg::CMD_COUNT, 0, 0, 0, 0);
        send_item(mlcq_pkg::CMD_GET, 0, 0, 0, 3);
        send_item(mlcq_pkg::CMD_GET, 0, 0, 0, LEN_MAX);
        send_item(mlcq_pkg::CMD_GET, 3, 0, 0, LEN_MAX);
        send_item(mlcq_pkg::CMD_PUT, 7, 32'h10, 4, 0);
        send_item(mlcq_pkg::CMD_COUNT, 4, 0, 0, 0);
        send_item(3'd6, 0, 32'h1, 1, 1);
        send_item(3'd7, 5, 32'h1, 1, 1);
        send_item(mlcq_pkg::CMD_CLEAR, 6, 0, 0, 0);
        drain_results();
    endtask

    task automatic test_join_mode();
        write_reg(mlcq_pkg::REG_JOIN_MODE, 7'd1);
        send_item(mlcq_pkg::CMD_PUT, 1, 32'h1000, 16, 0);
        send_item(mlcq_pkg::CMD_PUT, 1, 32'h1010, 16, 0);
        send_item(mlcq_pkg::CMD_UNGET, 1, 32'h0FF0, 16, 0);
        send_item(mlcq_pkg::CMD_PUT, 1, 32'h1020, LEN_MAX, 0);
        send_item(mlcq_pkg::CMD_PEEK, 1, 0, 0, 20);
        send_item(mlcq_pkg::CMD_GET, 1, 0, 0, 0);
        send_item(mlcq_pkg::CMD_GET, 1, 0, 0, 7);
        send_item(mlcq_pkg::CMD_COUNT, 1, 0, 0, 0);
        send_item(mlcq_pkg::CMD_PUT, 2, 32'hFFFF_FFF0, 32, 0);
        send_item(mlcq_pkg::CMD_GET, 2, 0, 0, 20);
        drain_results();
    endtask

    // small pool so that pool-empty is reached
    task automatic test_pool_empty();
        write_reg(mlcq_pkg::REG_POOL_USED, 7'd0);
        send_item(mlcq_pkg::CMD_CLEAR, 0, 0, 0, 0);
        send_item(mlcq_pkg::CMD_PUT, 0, 32'h40, 4, 0);
        send_item(mlcq_pkg::CMD_UNGET, 1, 32'h80, 4, 0);
        send_item(mlcq_pkg::CMD_GET, 0, 0, 0, 4);
        send_item(mlcq_pkg::CMD_UNGET, 1, 32'h200, 4, 0);
        drain_results();
        write_reg(mlcq_pkg::REG_POOL_USED, 7'd127);
        send_item(mlcq_pkg::CMD_CLEAR, 0, 0, 0, 0);
        drain_results();
    endtask

    task automatic random_item();
        int k;
        logic [2:0] ln;
        logic [mlcq_pkg::ADDR_W-1:0] ca;
        logic [mlcq_pkg::LEN_W-1:0] cl, rq;
        k = $urandom_range(99);
        ln = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
        ca = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(64)) << 4;
        cl = ($urandom_range(3) == 0) ? mlcq_pkg::LEN_W'($urandom())
                                      : mlcq_pkg::LEN_W'($urandom_range(4)) << 4;
        rq = ($urandom_range(3) == 0) ? mlcq_pkg::LEN_W'($urandom())
                                      : mlcq_pkg::LEN_W'($urandom_range(80));
        if (k < 35)
            send_item(mlcq_pkg::CMD_PUT, ln, ca, cl, rq);
        else if (k < 45)
            send_item(mlcq_pkg::CMD_UNGET, ln, ca, cl, rq);
        else if (k < 72)
            send_item(mlcq_pkg::CMD_GET, ln, ca, cl, rq);
        else if (k < 84)
            send_item(mlcq_pkg::CMD_PEEK, ln, ca, cl, rq);
        else if (k < 96)
            send_item(mlcq_pkg::CMD_COUNT, ln, ca, cl, rq);
        else if (k < 98)
            send_item(mlcq_pkg::CMD_CLEAR, ln, ca, cl, rq);
        else
            send_item(3'($urandom_range(6, 7)), ln, ca, cl, rq);
    endtask

    task automatic test_random();
        int idle_s [4] = '{0, 63, 0, 31};
        int idle_r [4] = '{0, 0, 63, 31};
        int pools [4] = '{64, 8, 1, 20};
        for (int p = 0; p < 4; p++)
        begin
            write_reg(mlcq_pkg::REG_JOIN_MODE, mlcq_pkg::CFG_W'(p % 2));
            write_reg(mlcq_pkg::REG_POOL_USED, mlcq_pkg::CFG_W'(pools[p]));
            send_item(mlcq_pkg::CMD_CLEAR, 0, 0, 0, 0);
            send_idle = idle_s[p];
            recv_stall = idle_r[p];
            repeat (120) random_item();
            drain_results();
        end
        send_idle = 0;
        recv_stall = 0;
    endtask

    initial
    begin
        sh_join = 1'b0;
        sh_pool = mlcq_pkg::POOL_USED_RST;
        rebuild_pool();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_join_mode();
        test_pool_empty();
        test_random();
        drain_results();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

/* files.f */
hdl/mlcq_pkg.sv
hdl/mlcq_ram.sv
hdl/mlcq_ctrl.sv
hdl/mlcq_dp.sv
hdl/multi_lane_chunk_queue.sv
tb/multi_lane_chunk_queue_test.sv
